// ----- sv/spsg_pkg.sv -----
// Shared types, constants and table for the stereo tone and noise generator.
package spsg_pkg;

  // Widths.  Every counter and period lives in whole samples: all of them
  // stay multiples of the sub-step scale, so the scale drops out.
  localparam int TONE_W   = 10;
  localparam int CNT_W    = 11;
  localparam int WEIGHT_W = 14;
  localparam int SAMPLE_W = 15;
  localparam int SUM_W    = WEIGHT_W + 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 15'h7fff;

  // Input commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_BIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_TAPS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_INVERT  = 2'd3;

  // Chip register numbers; the odd ones are attenuations.
  localparam logic [2:0] REG_TONE_A = 3'd0;
  localparam logic [2:0] REG_TONE_B = 3'd2;
  localparam logic [2:0] REG_TONE_C = 3'd4;
  localparam logic [2:0] REG_NOISE  = 3'd6;

  // Noise rate code that borrows twice the period of tone C.
  localparam logic [1:0] NOISE_RATE_TONE = 2'd3;

  localparam logic [CFG_W-1:0] FEEDBACK_RST = 16'h8000;
  localparam logic [CFG_W-1:0] TAPS_RST     = 16'h0006;
  localparam logic [15:0]      SEED_RST     = 16'h4000;

  typedef enum logic {ST_IDLE, ST_EXEC} spsg_state_t;

  typedef struct packed {
    logic capture;
    logic do_write;
    logic do_tick;
  } spsg_cmd_t;

  typedef struct packed {
    logic cmd_tick;
  } spsg_stat_t;

  // 2 dB attenuation steps, code 15 is silence.
  function automatic logic [WEIGHT_W-1:0] atten_weight(input logic [3:0] code);
    logic [WEIGHT_W-1:0] w;
    case (code)
      4'd0:    w = 14'd10922;
      4'd1:    w = 14'd8675;
      4'd2:    w = 14'd6891;
      4'd3:    w = 14'd5473;
      4'd4:    w = 14'd4348;
      4'd5:    w = 14'd3453;
      4'd6:    w = 14'd2743;
      4'd7:    w = 14'd2179;
      4'd8:    w = 14'd1731;
      4'd9:    w = 14'd1374;
      4'd10:   w = 14'd1092;
      4'd11:   w = 14'd867;
      4'd12:   w = 14'd689;
      4'd13:   w = 14'd547;
      4'd14:   w = 14'd434;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

  // A zero tone value counts as a period of one sample.
  function automatic logic [TONE_W-1:0] tone_period(input logic [TONE_W-1:0] t);
    return (t == '0) ? TONE_W'(1) : t;
  endfunction

endpackage

// ----- sv/spsg_in_if.sv -----
// Input channel: valid/ready handshake with command, port and write byte.
interface spsg_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       port;
  logic [7:0] write_byte;

  modport source (output valid, command, port, write_byte, input ready);
  modport sink   (input valid, command, port, write_byte, output ready);
endinterface

// ----- sv/spsg_out_if.sv -----
// Result channel: valid/ready handshake with left and right samples.
interface spsg_out_if import spsg_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// ----- sv/stereo_psg_tone_noise_generator.sv -----
// Top level of the two-port stereo tone and noise generator.
// Flow: a tick word is captured in idle and runs in execute, which registers
//   its sample pair; no new word is accepted until execute is done, and a
//   tick waits in execute only while the previous sample is still untaken.
// Reset (rst_n low, synchronous): configuration to defaults, chip registers,
//   counters, levels and noise shifter to power-on values, output empty.
module stereo_psg_tone_noise_generator import spsg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  spsg_in_if.sink              in_if,
  spsg_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Controller and datapath talk only through these.
  spsg_cmd_t  cmd;
  spsg_stat_t stat;

  // The controller takes one word in idle, then either applies a register
  // write or runs one sample tick; the output register keeps the sample
  // until taken, and a new word may be accepted meanwhile.
  spsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the chip registers of both ports, the three audible
  // tone lanes (port 1) and the port 0 noise channel. Counters run in whole
  // samples; each heard channel adds its weight when its level was high.
  spsg_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_if.command),
    .in_port       (in_if.port),
    .in_write_byte (in_if.write_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .left_sample   (out_if.left_sample),
    .right_sample  (out_if.right_sample)
  );

endmodule

// ----- sv/spsg_ctrl.sv -----
// Controller: accepts words, sequences write/tick execution, owns output valid.
module spsg_ctrl import spsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  spsg_stat_t stat,
  output spsg_cmd_t  cmd
);

  spsg_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stat.cmd_tick) begin
          cmd.do_write = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          // output slot free (or being freed): load a new sample
          cmd.do_tick = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.do_tick)    out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  a_tick_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && stat.cmd_tick && out_valid_r && !out_ready)
      |=> state_r == ST_EXEC)
    else $error("tick went ahead over an untaken sample");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.do_tick))
    else $error("output valid rose without a tick");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_write || cmd.do_tick) |=> state_r == ST_IDLE)
    else $error("controller stayed busy after execution");

endmodule

// ----- sv/spsg_dpath.sv -----
// Datapath: chip registers, tone/noise counters, noise shifter, sample mix.
module spsg_dpath import spsg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spsg_cmd_t            cmd,
  output spsg_stat_t           stat,
  input  logic                 in_command,
  input  logic                 in_port,
  input  logic [7:0]           in_write_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic [SAMPLE_W-1:0]  left_sample,
  output logic [SAMPLE_W-1:0]  right_sample
);

  // captured word
  logic       command_r, command_nxt;
  logic       port_r, port_nxt;
  logic [7:0] byte_r, byte_nxt;

  // configuration
  logic             oe_r, oe_nxt;
  logic [CFG_W-1:0] fbbit_r, fbbit_nxt;
  logic [CFG_W-1:0] taps_r, taps_nxt;
  logic             inv_r, inv_nxt;

  // chip registers
  logic [2:0]        latched_r [2];
  logic [2:0]        latched_nxt [2];
  logic [TONE_W-1:0] tone_r [2][3];
  logic [TONE_W-1:0] tone_nxt [2][3];
  logic [1:0]        mode_r, mode_nxt;       // port 0 noise rate
  logic [WEIGHT_W-1:0] weight_r [8];
  logic [WEIGHT_W-1:0] weight_nxt [8];

  // port 1 tone lanes and port 0 noise channel
  logic [CNT_W-1:0] cnt_r [3];
  logic [CNT_W-1:0] cnt_nxt [3];
  logic             lvl_r [3];
  logic             lvl_nxt [3];
  logic [CNT_W-1:0] ncnt_r, ncnt_nxt;
  logic [CNT_W-1:0] nper_r, nper_nxt;
  logic             nlvl_r, nlvl_nxt;
  logic             white_r, white_nxt;
  logic [15:0]      shift_r, shift_nxt;

  logic [SAMPLE_W-1:0] left_r, left_nxt;
  logic [SAMPLE_W-1:0] right_r, right_nxt;

  // write decode
  logic              latch;
  logic [2:0]        reg_sel;
  logic [TONE_W-1:0] tcur, tnew;
  logic [CNT_W-1:0]  twice_cur, twice_new;

  // tick terms
  logic [CNT_W-1:0] ca;
  logic [CNT_W-1:0] cd;
  logic [15:0]      sh;
  logic [15:0]      tapped;
  logic             fb;
  logic [SUM_W-1:0] lsum, rsum;

  always_comb begin
    latch   = byte_r[7];
    reg_sel = latch ? byte_r[6:4] : latched_r[port_r];
    case (reg_sel[2:1])
      2'd0:    tcur = tone_r[port_r][0];
      2'd1:    tcur = tone_r[port_r][1];
      2'd2:    tcur = tone_r[port_r][2];
      default: tcur = '0;
    endcase
    tnew      = latch ? {tcur[TONE_W-1:4], byte_r[3:0]} : {byte_r[5:0], tcur[3:0]};
    twice_cur = {tone_period(tone_r[0][2]), 1'b0};
    twice_new = {tone_period(tnew), 1'b0};
  end

  always_comb begin
    command_nxt = command_r;
    port_nxt    = port_r;
    byte_nxt    = byte_r;
    oe_nxt      = oe_r;
    fbbit_nxt   = fbbit_r;
    taps_nxt    = taps_r;
    inv_nxt     = inv_r;
    latched_nxt = latched_r;
    tone_nxt    = tone_r;
    mode_nxt    = mode_r;
    weight_nxt  = weight_r;
    cnt_nxt     = cnt_r;
    lvl_nxt     = lvl_r;
    ncnt_nxt    = ncnt_r;
    nper_nxt    = nper_r;
    nlvl_nxt    = nlvl_r;
    white_nxt   = white_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    ca          = '0;
    cd          = '0;
    sh          = '0;
    tapped      = '0;
    fb          = 1'b0;
    lsum        = '0;
    rsum        = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_OUTPUT_ENABLE: oe_nxt    = cfg_wdata[0];
        CFG_FEEDBACK_BIT:  fbbit_nxt = cfg_wdata;
        CFG_WHITE_TAPS:    taps_nxt  = cfg_wdata;
        CFG_WHITE_INVERT:  inv_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end

    if (cmd.capture) begin
      command_nxt = in_command;
      port_nxt    = in_port;
      byte_nxt    = in_write_byte;
    end

    if (cmd.do_write) begin
      if (latch) latched_nxt[port_r] = reg_sel;
      case (reg_sel)
        REG_TONE_A, REG_TONE_B, REG_TONE_C: begin
          tone_nxt[port_r][reg_sel[2:1]] = tnew;
          if (reg_sel == REG_TONE_C && !port_r && mode_r == NOISE_RATE_TONE)
            nper_nxt = twice_new;
        end
        REG_NOISE: begin
          // only port 0 noise is heard; reseed on every port 0 noise write
          if (!port_r) begin
            mode_nxt  = byte_r[1:0];
            white_nxt = byte_r[2];
            nper_nxt  = (byte_r[1:0] == NOISE_RATE_TONE) ? twice_cur
                        : (CNT_W'(32) << byte_r[1:0]);
            shift_nxt = fbbit_r;
            nlvl_nxt  = fbbit_r[0];
          end
        end
        default: weight_nxt[{port_r, reg_sel[2:1]}] = atten_weight(byte_r[3:0]);
      endcase
    end

    if (cmd.do_tick) begin
      for (int j = 0; j < 3; j++) begin
        ca = (weight_r[4+j] == '0 && cnt_r[j] <= CNT_W'(1)) ? cnt_r[j] + CNT_W'(1)
             : cnt_r[j];
        cd = ca - CNT_W'(1);
        if (cd == '0) begin
          cnt_nxt[j] = CNT_W'(tone_period(tone_r[1][j]));
          lvl_nxt[j] = ~lvl_r[j];
        end else begin
          cnt_nxt[j] = cd;
        end
      end

      ca = (weight_r[3] == '0 && ncnt_r <= CNT_W'(1)) ? ncnt_r + CNT_W'(1) : ncnt_r;
      cd = ca - CNT_W'(1);
      if (cd == '0) begin
        tapped = shift_r & taps_r;
        fb     = white_r ? (tapped != taps_r && tapped != '0) : shift_r[0];
        sh     = {1'b0, shift_r[15:1]} | (fb ? fbbit_r : '0);
        shift_nxt = sh;
        nlvl_nxt  = (white_r && inv_r) ? ~sh[0] : sh[0];
        ncnt_nxt  = nper_r;
      end else begin
        ncnt_nxt = cd;
      end

      // each channel contributes its level from before this tick
      if (oe_r) begin
        lsum = (lvl_r[0] ? SUM_W'(weight_r[4]) : '0) + (lvl_r[1] ? SUM_W'(weight_r[5]) : '0)
             + (lvl_r[2] ? SUM_W'(weight_r[6]) : '0) + (nlvl_r ? SUM_W'(weight_r[7]) : '0);
        rsum = (lvl_r[0] ? SUM_W'(weight_r[0]) : '0) + (lvl_r[1] ? SUM_W'(weight_r[1]) : '0)
             + (lvl_r[2] ? SUM_W'(weight_r[2]) : '0) + (nlvl_r ? SUM_W'(weight_r[3]) : '0);
      end
      left_nxt  = lsum[SUM_W-1] ? SAMPLE_MAX : lsum[SAMPLE_W-1:0];
      right_nxt = rsum[SUM_W-1] ? SAMPLE_MAX : rsum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    command_r <= command_nxt;
    port_r    <= port_nxt;
    byte_r    <= byte_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    if (!rst_n) begin
      oe_r    <= 1'b1;
      fbbit_r <= FEEDBACK_RST;
      taps_r  <= TAPS_RST;
      inv_r   <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        latched_r[p] <= '0;
        for (int k = 0; k < 3; k++) tone_r[p][k] <= '0;
      end
      mode_r <= '0;
      for (int i = 0; i < 8; i++) weight_r[i] <= '0;
      for (int j = 0; j < 3; j++) begin
        cnt_r[j] <= CNT_W'(1);
        lvl_r[j] <= 1'b0;
      end
      ncnt_r  <= CNT_W'(1);
      nper_r  <= CNT_W'(1);
      nlvl_r  <= 1'b0;
      white_r <= 1'b0;
      shift_r <= SEED_RST;
    end else begin
      oe_r      <= oe_nxt;
      fbbit_r   <= fbbit_nxt;
      taps_r    <= taps_nxt;
      inv_r     <= inv_nxt;
      latched_r <= latched_nxt;
      tone_r    <= tone_nxt;
      mode_r    <= mode_nxt;
      weight_r  <= weight_nxt;
      cnt_r     <= cnt_nxt;
      lvl_r     <= lvl_nxt;
      ncnt_r    <= ncnt_nxt;
      nper_r    <= nper_nxt;
      nlvl_r    <= nlvl_nxt;
      white_r   <= white_nxt;
      shift_r   <= shift_nxt;
    end
  end

  assign stat.cmd_tick = (command_r == CMD_TICK);
  assign left_sample   = left_r;
  assign right_sample  = right_r;

  a_noise_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    ncnt_r != '0)
    else $error("noise counter reached zero between ticks");

  a_noise_per_live: assert property (@(posedge clk) disable iff (!rst_n)
    nper_r != '0)
    else $error("noise period is zero");

  a_tone_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_tick && cnt_r[0] == CNT_W'(1) && weight_r[4] != '0)
      |=> lvl_r[0] != $past(lvl_r[0]))
    else $error("tone lane did not toggle on expiry");

endmodule
